// ===== rtl/rbfa_pkg.sv =====
// shared constants and register codes for the report buffer flush accounting core
package rbfa_pkg;

   // region defaults and limits
   localparam int NUM_REGIONS_DEF = 8;
   localparam int MASK_W          = 8;

   // field widths
   localparam int TOTAL_W   = 48;
   localparam int COUNT_W   = 11;
   localparam int LIMIT_W   = 10;
   localparam int STARTUP_W = 16;
   localparam int WORDPEN_W = 8;
   localparam int WPV_W     = 5;
   localparam int QUERY_W   = 16;
   localparam int ACTIVE_W  = 4;
   localparam int CHIP_W    = 7;
   localparam int UNIT_W    = WORDPEN_W + WPV_W;
   localparam int PROD_W    = COUNT_W + UNIT_W;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VECTOR_LIMIT     = 3'd0,
      CSR_STARTUP_PENALTY  = 3'd1,
      CSR_WORD_PENALTY     = 3'd2,
      CSR_WORDS_PER_VECTOR = 3'd3,
      CSR_QUERY_PENALTY    = 3'd4,
      CSR_ACTIVE_REGIONS   = 3'd5,
      CSR_CHIP_REGIONS     = 3'd6
   } csr_index_type;

   // register reset values
   localparam logic [LIMIT_W-1:0]   RST_VECTOR_LIMIT     = 10'd255;
   localparam logic [STARTUP_W-1:0] RST_STARTUP_PENALTY  = 16'd0;
   localparam logic [WORDPEN_W-1:0] RST_WORD_PENALTY     = 8'd1;
   localparam logic [WPV_W-1:0]     RST_WORDS_PER_VECTOR = 5'd1;
   localparam logic [QUERY_W-1:0]   RST_QUERY_PENALTY    = 16'd0;
   localparam logic [ACTIVE_W-1:0]  RST_ACTIVE_REGIONS   = 4'd8;
   localparam logic [CHIP_W-1:0]    RST_CHIP_REGIONS     = 7'd8;

endpackage

// ===== rtl/report_buffer_flush_accounting_core.sv =====
// report buffer flush accounting core: cycle total, region counts and drain sequencer
//
//   channel | direction | signals                                   | handshake
//   req     | in        | req_action, req_region_mask               | req_valid / req_ready
//   rsp     | out       | rsp_total_cycles, rsp_drained             | rsp_valid / rsp_ready
//   csr     | in        | csr_index, csr_wdata                      | csr_we, no wait
//
// a symbol request without drain passes through accept, limit check and result load.
// a drain adds a unit cost setup step, then a multiply step and an add step per
// on-chip region; a finish request goes from accept into the drain, then result load.
// every charge goes through one saturating adder.
// synchronous active high reset clears counts, total and the sequencer and loads the register reset values.
// req_ready is high only while the sequencer is idle; a held result (rsp_ready low)
// stalls the sequencer in its result load step.
module report_buffer_flush_accounting_core #(
   parameter int NUM_REGIONS = rbfa_pkg::NUM_REGIONS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_action,
   input  logic [rbfa_pkg::MASK_W-1:0]     req_region_mask,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rbfa_pkg::TOTAL_W-1:0]    rsp_total_cycles,
   output logic                            rsp_drained,
   // configuration port
   input  logic                            csr_we,
   input  logic [rbfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rbfa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // only regions covered by the mask can ever hold vectors
   localparam int NCNT = (NUM_REGIONS < rbfa_pkg::MASK_W) ? NUM_REGIONS : rbfa_pkg::MASK_W;
   localparam int IDXW = (NCNT > 1) ? $clog2(NCNT) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_PREP,
      S_WALK,
      S_ADD,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [rbfa_pkg::LIMIT_W-1:0]   limit_ff,   limit_in;
   logic [rbfa_pkg::STARTUP_W-1:0] startup_ff, startup_in;
   logic [rbfa_pkg::WORDPEN_W-1:0] wordpen_ff, wordpen_in;
   logic [rbfa_pkg::WPV_W-1:0]     wpv_ff,     wpv_in;
   logic [rbfa_pkg::QUERY_W-1:0]   query_ff,   query_in;
   logic [rbfa_pkg::ACTIVE_W-1:0]  active_ff,  active_in;
   logic [rbfa_pkg::CHIP_W-1:0]    chip_ff,    chip_in;

   // architectural state
   logic [rbfa_pkg::COUNT_W-1:0]   count_ff [NCNT];
   logic [rbfa_pkg::COUNT_W-1:0]   count_in [NCNT];
   logic [rbfa_pkg::TOTAL_W-1:0]   total_ff, total_in;

   // sequencer working registers
   logic                           any_ff, any_in;
   logic [rbfa_pkg::CHIP_W-1:0]    idx_ff, idx_in;
   logic [rbfa_pkg::UNIT_W-1:0]    unit_ff, unit_in;
   logic [rbfa_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic                           drained_ff, drained_in;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rbfa_pkg::TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;
   logic                           rsp_drained_ff, rsp_drained_in;

   // shared saturating adder
   logic [rbfa_pkg::PROD_W-1:0]    add_operand;
   logic [rbfa_pkg::TOTAL_W:0]     add_sum;
   logic [rbfa_pkg::TOTAL_W-1:0]   add_sat;

   logic                           over;
   logic                           walk_hit;
   logic [rbfa_pkg::COUNT_W-1:0]   walk_count;
   logic [rbfa_pkg::CHIP_W:0]      idx_next;

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_total_cycles = rsp_total_ff;
   assign rsp_drained      = rsp_drained_ff;

   // adder operand select
   always_comb begin
      unique case (state_ff)
         S_IDLE:  add_operand = rbfa_pkg::PROD_W'(1);
         S_PREP:  add_operand = rbfa_pkg::PROD_W'(startup_ff);
         S_ADD:   add_operand = prod_ff;
         default: add_operand = '0;
      endcase
   end

   assign add_sum = {1'b0, total_ff} + (rbfa_pkg::TOTAL_W + 1)'(add_operand);
   assign add_sat = (add_sum >= {1'b0, rbfa_pkg::TOTAL_MAX}) ? rbfa_pkg::TOTAL_MAX
                                                             : add_sum[rbfa_pkg::TOTAL_W-1:0];

   // limit check over active regions
   always_comb begin
      over = 1'b0;
      for (int i = 0; i < NCNT; i++) begin
         if (i < int'(active_ff) &&
             count_ff[i] > rbfa_pkg::COUNT_W'(limit_ff)) begin
            over = 1'b1;
         end
      end
   end

   // region picked by the drain walk
   assign walk_count = count_ff[idx_ff[IDXW-1:0]];
   assign walk_hit   = (int'(idx_ff) < NCNT) && (idx_ff < rbfa_pkg::CHIP_W'(active_ff)) &&
                       (walk_count != '0);
   assign idx_next   = {1'b0, idx_ff} + (rbfa_pkg::CHIP_W + 1)'(1);

   // next state and datapath
   always_comb begin
      state_in       = state_ff;
      limit_in       = limit_ff;
      startup_in     = startup_ff;
      wordpen_in     = wordpen_ff;
      wpv_in         = wpv_ff;
      query_in       = query_ff;
      active_in      = active_ff;
      chip_in        = chip_ff;
      count_in       = count_ff;
      total_in       = total_ff;
      any_in         = any_ff;
      idx_in         = idx_ff;
      unit_in        = unit_ff;
      prod_in        = prod_ff;
      drained_in     = drained_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_total_in   = rsp_total_ff;
      rsp_drained_in = rsp_drained_ff;

      // register writes
      if (csr_we) begin
         case (csr_index)
            rbfa_pkg::CSR_VECTOR_LIMIT:     limit_in   = csr_wdata[rbfa_pkg::LIMIT_W-1:0];
            rbfa_pkg::CSR_STARTUP_PENALTY:  startup_in = csr_wdata[rbfa_pkg::STARTUP_W-1:0];
            rbfa_pkg::CSR_WORD_PENALTY:     wordpen_in = csr_wdata[rbfa_pkg::WORDPEN_W-1:0];
            rbfa_pkg::CSR_WORDS_PER_VECTOR: wpv_in     = csr_wdata[rbfa_pkg::WPV_W-1:0];
            rbfa_pkg::CSR_QUERY_PENALTY:    query_in   = csr_wdata[rbfa_pkg::QUERY_W-1:0];
            rbfa_pkg::CSR_ACTIVE_REGIONS:   active_in  = csr_wdata[rbfa_pkg::ACTIVE_W-1:0];
            rbfa_pkg::CSR_CHIP_REGIONS:     chip_in    = csr_wdata[rbfa_pkg::CHIP_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               drained_in = 1'b0;
               if (req_action) begin
                  state_in = S_PREP;
               end else begin
                  // symbol: a charge of 1 to the total, reporting active regions counted
                  total_in = add_sat;
                  any_in   = 1'b0;
                  for (int i = 0; i < NCNT; i++) begin
                     if (req_region_mask[i] && i < int'(active_ff)) begin
                        any_in = 1'b1;
                        if (count_ff[i] != rbfa_pkg::COUNT_MAX) begin
                           count_in[i] = count_ff[i] + rbfa_pkg::COUNT_W'(1);
                        end
                     end
                  end
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            state_in = (any_ff && over) ? S_PREP : S_OUT;
         end
         S_PREP: begin
            // startup charge and per-vector cost
            total_in   = add_sat;
            unit_in    = rbfa_pkg::UNIT_W'(wordpen_ff) * rbfa_pkg::UNIT_W'(wpv_ff);
            idx_in     = '0;
            drained_in = 1'b1;
            state_in   = (chip_ff == '0) ? S_OUT : S_WALK;
         end
         S_WALK: begin
            if (walk_hit) begin
               prod_in = rbfa_pkg::PROD_W'(walk_count) * rbfa_pkg::PROD_W'(unit_ff);
               count_in[idx_ff[IDXW-1:0]] = '0;
            end else begin
               prod_in = rbfa_pkg::PROD_W'(query_ff);
            end
            state_in = S_ADD;
         end
         S_ADD: begin
            total_in = add_sat;
            idx_in   = idx_next[rbfa_pkg::CHIP_W-1:0];
            state_in = (idx_next >= {1'b0, chip_ff}) ? S_OUT : S_WALK;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_total_in   = total_ff;
               rsp_drained_in = drained_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state, registers and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= rbfa_pkg::RST_VECTOR_LIMIT;
         startup_ff   <= rbfa_pkg::RST_STARTUP_PENALTY;
         wordpen_ff   <= rbfa_pkg::RST_WORD_PENALTY;
         wpv_ff       <= rbfa_pkg::RST_WORDS_PER_VECTOR;
         query_ff     <= rbfa_pkg::RST_QUERY_PENALTY;
         active_ff    <= rbfa_pkg::RST_ACTIVE_REGIONS;
         chip_ff      <= rbfa_pkg::RST_CHIP_REGIONS;
         for (int i = 0; i < NCNT; i++) begin
            count_ff[i] <= '0;
         end
         total_ff     <= '0;
         any_ff       <= 1'b0;
         drained_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         startup_ff   <= startup_in;
         wordpen_ff   <= wordpen_in;
         wpv_ff       <= wpv_in;
         query_ff     <= query_in;
         active_ff    <= active_in;
         chip_ff      <= chip_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         any_ff       <= any_in;
         drained_ff   <= drained_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      unit_ff        <= unit_in;
      prod_ff        <= prod_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_drained_ff <= rsp_drained_in;
   end

endmodule

// ===== dv/tb_report_buffer_flush_accounting_core.sv =====
// testbench for the report buffer flush accounting core: predicted totals and drain flags checked per response
`timescale 1ns / 100ps

module tb_report_buffer_flush_accounting_core;

   // request actions and the spare register slot
   localparam bit ACT_SYMBOL = 1'b0;
   localparam bit ACT_FINISH = 1'b1;
   localparam logic [rbfa_pkg::CSR_IDX_W-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam int CYCLE_LIMIT = 5_000_000;

   typedef struct packed {
      logic [rbfa_pkg::TOTAL_W-1:0] total;
      logic                         drained;
   } cycle_report_type;

   typedef struct {
      bit [15:0] limit, startup, word_pen, wpv, query, active, chip;
   } csr_set_type;

   // cycle ledger: mirrors region counts and the running total
   class flush_ledger;
      bit [rbfa_pkg::LIMIT_W-1:0]   vector_limit;
      bit [rbfa_pkg::STARTUP_W-1:0] startup_penalty;
      bit [rbfa_pkg::WORDPEN_W-1:0] word_penalty;
      bit [rbfa_pkg::WPV_W-1:0]     words_per_vector;
      bit [rbfa_pkg::QUERY_W-1:0]   query_penalty;
      bit [rbfa_pkg::ACTIVE_W-1:0]  active_regions;
      bit [rbfa_pkg::CHIP_W-1:0]    chip_regions;
      bit [rbfa_pkg::COUNT_W-1:0]   region_count [rbfa_pkg::NUM_REGIONS_DEF];
      bit [rbfa_pkg::TOTAL_W-1:0]   cycle_total;
      cycle_report_type             owed_reports [$];
      int                           errors;

      function new();
         vector_limit     = rbfa_pkg::RST_VECTOR_LIMIT;
         startup_penalty  = rbfa_pkg::RST_STARTUP_PENALTY;
         word_penalty     = rbfa_pkg::RST_WORD_PENALTY;
         words_per_vector = rbfa_pkg::RST_WORDS_PER_VECTOR;
         query_penalty    = rbfa_pkg::RST_QUERY_PENALTY;
         active_regions   = rbfa_pkg::RST_ACTIVE_REGIONS;
         chip_regions     = rbfa_pkg::RST_CHIP_REGIONS;
         foreach (region_count[i]) region_count[i] = '0;
         cycle_total = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [rbfa_pkg::CSR_IDX_W-1:0] idx, bit [15:0] value);
         case (idx)
            rbfa_pkg::CSR_VECTOR_LIMIT:
               vector_limit     = value[rbfa_pkg::LIMIT_W-1:0];
            rbfa_pkg::CSR_STARTUP_PENALTY:
               startup_penalty  = value[rbfa_pkg::STARTUP_W-1:0];
            rbfa_pkg::CSR_WORD_PENALTY:
               word_penalty     = value[rbfa_pkg::WORDPEN_W-1:0];
            rbfa_pkg::CSR_WORDS_PER_VECTOR:
               words_per_vector = value[rbfa_pkg::WPV_W-1:0];
            rbfa_pkg::CSR_QUERY_PENALTY:
               query_penalty    = value[rbfa_pkg::QUERY_W-1:0];
            rbfa_pkg::CSR_ACTIVE_REGIONS:
               active_regions   = value[rbfa_pkg::ACTIVE_W-1:0];
            rbfa_pkg::CSR_CHIP_REGIONS:
               chip_regions     = value[rbfa_pkg::CHIP_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return owed_reports.size();
      endfunction

      // saturating add into the running total
      function void charge(bit [63:0] amount);
         if (amount >= 64'(rbfa_pkg::TOTAL_MAX - cycle_total)) cycle_total = rbfa_pkg::TOTAL_MAX;
         else cycle_total = cycle_total + amount[rbfa_pkg::TOTAL_W-1:0];
      endfunction

      function int active_count();
         if (active_regions > rbfa_pkg::NUM_REGIONS_DEF) return rbfa_pkg::NUM_REGIONS_DEF;
         return int'(active_regions);
      endfunction

      // startup charge, then walk every on-chip region
      function void drain();
         int act;
         bit [63:0] cost;
         act = active_count();
         charge(64'(startup_penalty));
         for (int i = 0; i < int'(chip_regions); i++) begin
            if (i < act && region_count[i] != '0) begin
               cost = 64'(region_count[i]) * 64'(word_penalty) * 64'(words_per_vector);
               charge(cost);
               region_count[i] = '0;
            end else begin
               charge(64'(query_penalty));
            end
         end
      endfunction

      function void note_request(bit act_bit, bit [rbfa_pkg::MASK_W-1:0] mask);
         int n;
         bit any_hit, over, did;
         n = active_count();
         any_hit = 1'b0;
         over = 1'b0;
         did = 1'b0;
         if (act_bit == ACT_FINISH) begin
            drain();
            did = 1'b1;
         end else begin
            charge(64'd1);
            for (int i = 0; i < n && i < rbfa_pkg::MASK_W; i++) begin
               if (mask[i]) begin
                  any_hit = 1'b1;
                  if (region_count[i] != rbfa_pkg::COUNT_MAX) region_count[i]++;
               end
            end
            // limit check only when an active region reported
            if (any_hit) begin
               for (int i = 0; i < n; i++)
                  if (region_count[i] > vector_limit) over = 1'b1;
               if (over) begin
                  drain();
                  did = 1'b1;
               end
            end
         end
         owed_reports.push_back('{total: cycle_total, drained: did});
      endfunction

      function void check_response(logic [rbfa_pkg::TOTAL_W-1:0] total, logic drained);
         cycle_report_type want;
         if (owed_reports.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected response: total_cycles=%0d drained=%0b", total, drained);
            return;
         end
         want = owed_reports.pop_front();
         if (total !== want.total || drained !== want.drained) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: total_cycles exp %0d got %0d, drained exp %0b got %0b",
                        want.total, total, want.drained, drained);
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic                            req_action;
   logic [rbfa_pkg::MASK_W-1:0]     req_region_mask;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [rbfa_pkg::TOTAL_W-1:0]    rsp_total_cycles;
   logic                            rsp_drained;
   logic                            csr_we;
   logic [rbfa_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [rbfa_pkg::CSR_DATA_W-1:0] csr_wdata;

   flush_ledger ledger;
   int          cycle_count = 0;
   int          send_gap = 0;
   int          send_quiet = 0;
   int          recv_quiet = 0;

   report_buffer_flush_accounting_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_region_mask  (req_region_mask),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_total_cycles (rsp_total_cycles),
      .rsp_drained      (rsp_drained),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // idle cycles per request, with occasional stretches of back-to-back traffic
   function automatic int draw_gap(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         quiet = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   function automatic bit [15:0] pick_field(bit [15:0] hi);
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return hi;
         2: return 16'hFFFF;
         default: return 16'($urandom_range(0, hi));
      endcase
   endfunction

   function automatic csr_set_type random_setting();
      csr_set_type s;
      s.limit    = ($urandom_range(0, 2) != 0) ? 16'($urandom_range(0, 12))
                                               : pick_field(16'd1023);
      s.startup  = pick_field(16'd65535);
      s.word_pen = pick_field(16'd255);
      s.wpv      = pick_field(16'd16);
      s.query    = pick_field(16'd65535);
      s.active   = pick_field(16'd8);
      s.chip     = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 12))
                                               : pick_field(16'd64);
      return s;
   endfunction

   function automatic bit [8:0] random_request();
      bit [rbfa_pkg::MASK_W-1:0] m;
      case ($urandom_range(0, 7))
         0: m = '0;
         1: m = '1;
         2: m = 8'h01 << $urandom_range(0, 7);
         default: m = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 19) == 0) return {ACT_FINISH, m};
      return {ACT_SYMBOL, m};
   endfunction

   // register writes, back to back, enable dropped after the last
   task automatic put_reg(input logic [rbfa_pkg::CSR_IDX_W-1:0] idx, input bit [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      ledger.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic write_config(input csr_set_type s);
      put_reg(rbfa_pkg::CSR_VECTOR_LIMIT, s.limit);
      put_reg(rbfa_pkg::CSR_STARTUP_PENALTY, s.startup);
      put_reg(rbfa_pkg::CSR_WORD_PENALTY, s.word_pen);
      put_reg(rbfa_pkg::CSR_WORDS_PER_VECTOR, s.wpv);
      put_reg(rbfa_pkg::CSR_QUERY_PENALTY, s.query);
      put_reg(rbfa_pkg::CSR_ACTIVE_REGIONS, s.active);
      put_reg(rbfa_pkg::CSR_CHIP_REGIONS, s.chip);
      csr_we <= 1'b0;
   endtask

   // one request; valid stays up when the next one follows with no gap
   task automatic send_request(input bit act_bit, input bit [rbfa_pkg::MASK_W-1:0] mask,
                               input bit last);
      repeat (send_gap) @(posedge clock);
      if (!req_valid) req_valid <= 1'b1;
      req_action      <= act_bit;
      req_region_mask <= mask;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      ledger.note_request(act_bit, mask);
      send_gap = draw_gap(send_quiet);
      if (send_gap > 0 || last) req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   // send a list, sometimes holding off until all responses are back
   task automatic run_requests(input bit [8:0] items [$]);
      bit pause;
      for (int i = 0; i < items.size(); i++) begin
         pause = (i == items.size() - 1) || ($urandom_range(0, 39) == 0);
         send_request(items[i][8], items[i][7:0], pause);
         if (pause) wait_drained();
      end
   endtask

   // response side: random stalls, payload sampled mid-cycle
   initial begin
      logic [rbfa_pkg::TOTAL_W-1:0] got_total;
      logic                         got_drained;
      int                           gap;
      @(negedge reset);
      @(posedge clock);
      forever begin
         gap = draw_gap(recv_quiet);
         if (gap > 0) begin
            if (rsp_ready) rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         if (!rsp_ready) rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid);
         got_total   = rsp_total_cycles;
         got_drained = rsp_drained;
         @(posedge clock);
         ledger.check_response(got_total, got_drained);
      end
   end

   initial begin
      bit [8:0] items [$];
      csr_set_type s;
      ledger = new();
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_action      <= ACT_SYMBOL;
      req_region_mask <= '0;
      rsp_ready       <= 1'b0;
      csr_we          <= 1'b0;
      csr_index       <= rbfa_pkg::CSR_VECTOR_LIMIT;
      csr_wdata       <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_gap = draw_gap(send_quiet);

      // reset settings
      items = '{{ACT_SYMBOL, 8'hFF}, {ACT_FINISH, 8'h00}};
      run_requests(items);

      // small limit: inactive bits ignored, drain on overflow, empty finish
      put_reg(CSR_SPARE_INDEX, 16'hFFFF);
      s = '{limit: 16'd2, startup: 16'd100, word_pen: 16'd3, wpv: 16'd2, query: 16'd7,
            active: 16'd5, chip: 16'd6};
      write_config(s);
      items = '{{ACT_SYMBOL, 8'h00}, {ACT_SYMBOL, 8'hE0}, {ACT_SYMBOL, 8'h01},
                {ACT_SYMBOL, 8'h01}, {ACT_SYMBOL, 8'h01}, {ACT_SYMBOL, 8'hFF},
                {ACT_SYMBOL, 8'hFF}, {ACT_SYMBOL, 8'hFF}, {ACT_FINISH, 8'h00},
                {ACT_SYMBOL, 8'h1F}, {ACT_FINISH, 8'hFF}};
      run_requests(items);

      // active count above the region count, region beyond the chip walk
      s = '{limit: 16'd0, startup: 16'd65535, word_pen: 16'd255, wpv: 16'd16,
            query: 16'd65535, active: 16'd15, chip: 16'd3};
      write_config(s);
      items = '{{ACT_SYMBOL, 8'h80}, {ACT_SYMBOL, 8'h80}, {ACT_SYMBOL, 8'h00},
                {ACT_FINISH, 8'h00}};
      run_requests(items);

      // no active region, zero words per vector
      s = '{limit: 16'd1023, startup: 16'd0, word_pen: 16'd0, wpv: 16'd0, query: 16'd1,
            active: 16'd0, chip: 16'd64};
      write_config(s);
      items = '{{ACT_SYMBOL, 8'hFF}, {ACT_FINISH, 8'h00}, {ACT_SYMBOL, 8'h55}};
      run_requests(items);

      // every register at the top of its field
      s = '{limit: 16'hFFFF, startup: 16'hFFFF, word_pen: 16'hFFFF, wpv: 16'hFFFF,
            query: 16'hFFFF, active: 16'hFFFF, chip: 16'hFFFF};
      write_config(s);
      items = '{{ACT_SYMBOL, 8'hAA}, {ACT_FINISH, 8'h00}, {ACT_SYMBOL, 8'hFF}};
      run_requests(items);

      // random traffic over extreme and random settings
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: s = '{limit: 16'd0, startup: 16'd65535, word_pen: 16'd255, wpv: 16'd16,
                     query: 16'd65535, active: 16'd8, chip: 16'd64};
            1: s = '{limit: 16'd0, startup: 16'd0, word_pen: 16'd0, wpv: 16'd1,
                     query: 16'd0, active: 16'd1, chip: 16'd0};
            default: s = random_setting();
         endcase
         write_config(s);
         items.delete();
         repeat (140) items.push_back(random_request());
         run_requests(items);
      end

      // counts held past the limit: no region is walked, region 0 keeps growing
      s = '{limit: 16'd4, startup: 16'd1, word_pen: 16'd255, wpv: 16'd31, query: 16'd3,
            active: 16'd8, chip: 16'd0};
      write_config(s);
      items.delete();
      repeat (300) items.push_back({ACT_SYMBOL, 8'h01 | 8'($urandom_range(0, 255))});
      items.push_back({ACT_FINISH, 8'h00});
      run_requests(items);

      // release the grown counts
      s.chip = 16'd8;
      write_config(s);
      items = '{{ACT_FINISH, 8'h00}, {ACT_SYMBOL, 8'hFF}};
      run_requests(items);

      wait_drained();
      repeat (20) @(posedge clock);
      if (ledger.errors == 0 && ledger.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
